// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks with active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- sv/fltw_pkg.sv -----
// ----------------------------------------------------------------------------
// fltw_pkg
// shared types and constants of the four-level page table walker
// ----------------------------------------------------------------------------
package fltw_pkg;

  localparam int TABLE_COUNT_DEF = 64;

  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int FLAG_W   = 12;
  localparam int ENTRY_W  = 52;
  localparam int IDX_W    = 9;
  localparam int FRAME_W  = ENTRY_W - FLAG_W;
  localparam int ENTRIES  = 1 << IDX_W;

  localparam int L0_SHIFT = 39;
  localparam int L1_SHIFT = 30;
  localparam int L2_SHIFT = 21;
  localparam int L3_SHIFT = 12;

  localparam logic [FLAG_W-1:0] FLAG_PRESENT  = FLAG_W'(1);
  localparam logic [FLAG_W-1:0] FLAG_WRITABLE = FLAG_W'(2);

  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FIN
  } state_t;

endpackage

// ----- sv/fltw_ram.sv -----
// ----------------------------------------------------------------------------
// fltw_ram
// generic single-port ram, one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module fltw_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    rdata_r <= mem_q[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/four_level_page_table_walker_top.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// map, unmap and translate over a pool of 512-entry page tables in one ram
// ----------------------------------------------------------------------------
// After reset the table store is swept to zero, one entry per cycle, over
// all TABLE_COUNT*512 entries; in_ready stays low until the sweep ends.
// Then one request is handled at a time: every table access goes through
// the single port of the table ram with a registered read, so each of the
// three intermediate levels takes a read step, then a check step that may
// allocate a table. A rejected map (zero paddr) or an unused command goes
// straight to the finish state. The result word is held in an output
// register; the finish state loads the next result only once it is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_level_page_table_walker_top #(
  parameter int TABLE_COUNT = fltw_pkg::TABLE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [fltw_pkg::VA_W-1:0]  in_virt_addr,
  input  logic [fltw_pkg::PA_W-1:0]  in_phys_addr_in,
  input  logic [fltw_pkg::FLAG_W-1:0] in_entry_flags,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [fltw_pkg::PA_W-1:0]  out_phys_addr_out
);

  localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int NW    = TW + 1;
  localparam int DEPTH = TABLE_COUNT * fltw_pkg::ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = fltw_pkg::FRAME_W;

  fltw_pkg::state_t  state_r, state_nxt;
  fltw_pkg::cmd_t    cmd_r, cmd_nxt;
  fltw_pkg::status_t rstat_r, rstat_nxt;
  fltw_pkg::status_t out_status_r, out_status_nxt;

  logic [fltw_pkg::VA_W-1:0]   va_r, va_nxt;
  logic [FW-1:0]               pa_r, pa_nxt;
  logic [fltw_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic [1:0]                  lvl_r, lvl_nxt;
  logic [TW-1:0]               tbl_r, tbl_nxt;
  logic [NW-1:0]               nfree_r, nfree_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [fltw_pkg::PA_W-1:0]   rpa_r, rpa_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fltw_pkg::PA_W-1:0]   out_pa_r, out_pa_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic [fltw_pkg::ENTRY_W-1:0] mem_wdata;
  logic [fltw_pkg::ENTRY_W-1:0] mem_rdata;

  logic [fltw_pkg::IDX_W-1:0] slot_idx;
  logic                       ent_pres;
  logic [FW-1:0]              ent_idx;
  logic                       idx_ok;
  logic                       pool_full;
  logic                       in_acc;
  logic                       in_reject;
  logic                       fin_go;
  logic                       clr_done;

  fltw_ram #(
    .WIDTH (fltw_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // level index slice
  always_comb begin
    unique case (lvl_r)
      2'd0:    slot_idx = va_r[fltw_pkg::L0_SHIFT +: fltw_pkg::IDX_W];
      2'd1:    slot_idx = va_r[fltw_pkg::L1_SHIFT +: fltw_pkg::IDX_W];
      2'd2:    slot_idx = va_r[fltw_pkg::L2_SHIFT +: fltw_pkg::IDX_W];
      default: slot_idx = va_r[fltw_pkg::L3_SHIFT +: fltw_pkg::IDX_W];
    endcase
  end

  // shared entry check
  assign ent_pres  = mem_rdata[0];
  assign ent_idx   = mem_rdata[fltw_pkg::ENTRY_W-1:fltw_pkg::FLAG_W];
  assign idx_ok    = ent_pres && (ent_idx != '0) && (ent_idx < FW'(nfree_r));
  assign pool_full = (nfree_r >= NW'(TABLE_COUNT));

  assign in_acc    = in_valid && in_ready;
  assign in_reject = (in_cmd == fltw_pkg::CMD_NOP) ||
                     ((in_cmd == fltw_pkg::CMD_MAP) && (in_phys_addr_in == '0));
  assign fin_go    = (state_r == fltw_pkg::S_FIN) && (!out_valid_r || out_ready);
  assign clr_done  = (clr_r == AW'(DEPTH - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fltw_pkg::S_CLEAR: begin
        if (clr_done) begin
          state_nxt = fltw_pkg::S_IDLE;
        end
      end
      fltw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_reject ? fltw_pkg::S_FIN : fltw_pkg::S_READ;
        end
      end
      fltw_pkg::S_READ: begin
        if (lvl_r == fltw_pkg::LVL_LEAF && cmd_r != fltw_pkg::CMD_XLATE) begin
          state_nxt = fltw_pkg::S_FIN;
        end else begin
          state_nxt = fltw_pkg::S_EVAL;
        end
      end
      fltw_pkg::S_EVAL: begin
        priority if (lvl_r == fltw_pkg::LVL_LEAF) begin
          state_nxt = fltw_pkg::S_FIN;
        end else if (cmd_r == fltw_pkg::CMD_MAP && !ent_pres) begin
          state_nxt = pool_full ? fltw_pkg::S_FIN : fltw_pkg::S_READ;
        end else begin
          state_nxt = idx_ok ? fltw_pkg::S_READ : fltw_pkg::S_FIN;
        end
      end
      fltw_pkg::S_FIN: begin
        if (fin_go) begin
          state_nxt = fltw_pkg::S_IDLE;
        end
      end
      default: state_nxt = fltw_pkg::S_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt        = cmd_r;
    va_nxt         = va_r;
    pa_nxt         = pa_r;
    flags_nxt      = flags_r;
    lvl_nxt        = lvl_r;
    tbl_nxt        = tbl_r;
    nfree_nxt      = nfree_r;
    clr_nxt        = clr_r;
    rstat_nxt      = rstat_r;
    rpa_nxt        = rpa_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pa_nxt     = out_pa_r;
    mem_we         = 1'b0;
    mem_addr       = {tbl_r, slot_idx};
    mem_wdata      = '0;
    in_ready       = (state_r == fltw_pkg::S_IDLE);

    unique case (state_r)
      fltw_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = AW'(clr_r + 1'b1);
      end
      fltw_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = fltw_pkg::cmd_t'(in_cmd);
          va_nxt    = in_virt_addr;
          pa_nxt    = in_phys_addr_in[fltw_pkg::PA_W-1:fltw_pkg::FLAG_W];
          flags_nxt = in_entry_flags;
          lvl_nxt   = '0;
          tbl_nxt   = '0;
          rpa_nxt   = '0;
          rstat_nxt = (in_cmd == fltw_pkg::CMD_MAP && in_phys_addr_in == '0) ?
                      fltw_pkg::ST_ZERO : fltw_pkg::ST_OK;
        end
      end
      fltw_pkg::S_READ: begin
        if (lvl_r == fltw_pkg::LVL_LEAF && cmd_r != fltw_pkg::CMD_XLATE) begin
          mem_we    = 1'b1;
          mem_wdata = (cmd_r == fltw_pkg::CMD_MAP) ?
                      {pa_r, flags_r | fltw_pkg::FLAG_PRESENT} : '0;
          rstat_nxt = fltw_pkg::ST_OK;
        end
      end
      fltw_pkg::S_EVAL: begin
        priority if (lvl_r == fltw_pkg::LVL_LEAF) begin
          if (ent_pres) begin
            rpa_nxt = {ent_idx, va_r[fltw_pkg::FLAG_W-1:0]};
          end else begin
            rstat_nxt = fltw_pkg::ST_ABSENT;
          end
        end else if (cmd_r == fltw_pkg::CMD_MAP && !ent_pres) begin
          if (pool_full) begin
            rstat_nxt = fltw_pkg::ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {FW'(nfree_r),
                         flags_r | fltw_pkg::FLAG_PRESENT | fltw_pkg::FLAG_WRITABLE};
            tbl_nxt   = nfree_r[TW-1:0];
            nfree_nxt = NW'(nfree_r + 1'b1);
            lvl_nxt   = lvl_r + 2'd1;
          end
        end else if (idx_ok) begin
          tbl_nxt = ent_idx[TW-1:0];
          lvl_nxt = lvl_r + 2'd1;
        end else begin
          rstat_nxt = fltw_pkg::ST_ABSENT;
        end
      end
      fltw_pkg::S_FIN: begin
        if (fin_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rstat_r;
          out_pa_nxt     = rpa_r;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fltw_pkg::S_CLEAR;
      clr_r       <= '0;
      nfree_r     <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    va_r         <= va_nxt;
    pa_r         <= pa_nxt;
    flags_r      <= flags_nxt;
    lvl_r        <= lvl_nxt;
    tbl_r        <= tbl_nxt;
    rstat_r      <= rstat_nxt;
    rpa_r        <= rpa_nxt;
    out_status_r <= out_status_nxt;
    out_pa_r     <= out_pa_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_phys_addr_out = out_pa_r;

  // pool counter stays in range and only steps up by one
  `ASSERT_HOLDS(a_nfree_range, clk, rst_n, (nfree_r != '0) && (nfree_r <= NW'(TABLE_COUNT)))
  `ASSERT_HOLDS(a_nfree_step, clk, rst_n, $stable(nfree_r) || (nfree_r == NW'($past(nfree_r) + 1'b1)))
  // a table is only allocated while walking a map
  `ASSERT_HOLDS(a_alloc_map, clk, rst_n, (nfree_r != $past(nfree_r)) |-> ($past(state_r) == fltw_pkg::S_EVAL && $past(cmd_r) == fltw_pkg::CMD_MAP))
  // a new result word is only loaded from the finish state
  `ASSERT_HOLDS(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == fltw_pkg::S_FIN))
  // no request is accepted outside the idle state, so none before the sweep is over
  `ASSERT_NEVER(a_no_accept_clear, clk, rst_n, in_valid && in_ready && (state_r != fltw_pkg::S_IDLE))

endmodule
